[rtl/sfpp_pkg.sv]
// shared types and constants of the spi flash page program sequencer
package sfpp_pkg;

  localparam int unsigned PAGE_BYTES_DEF = 256;
  localparam int unsigned ADDR_W         = 24;
  localparam int unsigned POS_W          = 25;
  localparam int unsigned CNT_W          = 9;
  localparam int unsigned RUN_MAX        = 6;
  localparam int unsigned RUN_W          = 3;

  // input actions
  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_DATA   = 2'd1;
  localparam logic [1:0] ACT_STATUS = 2'd2;

  // result kinds
  localparam logic [2:0] K_KEEP          = 3'd0;
  localparam logic [2:0] K_RELEASE_AFTER = 3'd1;
  localparam logic [2:0] K_POLL          = 3'd2;
  localparam logic [2:0] K_RELEASE       = 3'd3;
  localparam logic [2:0] K_DONE          = 3'd4;
  localparam logic [2:0] K_ERROR         = 3'd5;

  // flash commands
  localparam logic [7:0] CMD_WREN = 8'h06;
  localparam logic [7:0] CMD_PP   = 8'h02;
  localparam logic [7:0] CMD_RDSR = 8'h05;
  localparam logic [7:0] SR_WIP   = 8'h01;

  localparam logic [POS_W-1:0] LEN_MAX = 25'h1000000;

  typedef struct packed {
    logic [1:0]  action;
    logic [23:0] start_address;
    logic [24:0] write_length;
    logic [7:0]  data_byte;
    logic [7:0]  status_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [7:0] spi_byte;
    logic       wants_data;
    logic       last_of_run;
  } out_word_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
  } run_ent_t;

endpackage

[rtl/spi_flash_page_program_sequencer_unit.sv]
// top level of the spi flash page program sequencer
// Each accepted input word is decoded combinationally into a run of one to six result
// words held in a small run buffer, which then drains one word per cycle while
// out_stall is low; an item causes one result for a data byte in mid chunk or a busy
// poll, three at the end of a chunk, and up to six when a poll opens the next chunk.
// A new input word is taken in the same cycle the last word of the current run
// leaves, so single-result items flow at one per cycle while out_stall is low.
// Chunks of PAGE_BYTES bytes are counted from the start address, not aligned to
// flash pages. Out of turn words give a single error result and leave the state alone.
module spi_flash_page_program_sequencer_unit
  import sfpp_pkg::*;
#(
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  // phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_POLL = 2'd2;

  localparam logic [CNT_W-1:0] PAGE_LIM = CNT_W'(PAGE_BYTES);

  // sequencer state
  logic [1:0]       phase_r, phase_nxt;
  logic [POS_W-1:0] cur_r, cur_nxt;
  logic [POS_W-1:0] end_r, end_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // run buffer
  run_ent_t         run_r [RUN_MAX];
  run_ent_t         run_nxt [RUN_MAX];
  logic [RUN_W-1:0] len_r, len_nxt;
  logic [RUN_W-1:0] idx_r;
  logic             wants_r;
  logic             out_valid_r;

  logic             in_fire, out_fire, run_last;
  logic [1:0]       ph;
  logic [POS_W-1:0] len_sat, cur_inc, open_addr;
  logic [CNT_W-1:0] cnt_inc;
  logic             chunk_last;

  assign run_last = (idx_r == len_r - RUN_W'(1));
  assign out_fire = out_valid_r && !out_stall;
  assign in_stall = out_valid_r && !(out_fire && run_last);
  assign in_fire  = in_valid && !in_stall;

  // unused phase code behaves as idle
  assign ph = (phase_r == PH_DATA || phase_r == PH_POLL) ? phase_r : PH_IDLE;

  assign len_sat    = (in_data.write_length > LEN_MAX) ? LEN_MAX : in_data.write_length;
  assign cur_inc    = cur_r + POS_W'(1);
  assign cnt_inc    = cnt_r + CNT_W'(1);
  assign chunk_last = (cur_inc >= end_r) || (cnt_inc >= PAGE_LIM);

  // decode one input word into the next state and the result run
  always_comb begin
    phase_nxt = phase_r;
    cur_nxt   = cur_r;
    end_nxt   = end_r;
    cnt_nxt   = cnt_r;
    len_nxt   = RUN_W'(1);
    open_addr = cur_r;
    for (int i = 0; i < RUN_MAX; i++) begin
      run_nxt[i] = '{kind: K_KEEP, data: 8'h00};
    end
    run_nxt[0] = '{kind: K_ERROR, data: 8'h00};

    if (in_data.action == ACT_START && ph == PH_IDLE) begin
      if (len_sat == '0) begin
        run_nxt[0] = '{kind: K_DONE, data: 8'h00};
      end else begin
        open_addr  = {1'b0, in_data.start_address};
        cur_nxt    = open_addr;
        end_nxt    = open_addr + len_sat;
        cnt_nxt    = '0;
        phase_nxt  = PH_DATA;
        len_nxt    = RUN_W'(5);
        run_nxt[0] = '{kind: K_RELEASE_AFTER, data: CMD_WREN};
        run_nxt[1] = '{kind: K_KEEP, data: CMD_PP};
        run_nxt[2] = '{kind: K_KEEP, data: open_addr[23:16]};
        run_nxt[3] = '{kind: K_KEEP, data: open_addr[15:8]};
        run_nxt[4] = '{kind: K_KEEP, data: open_addr[7:0]};
      end
    end else if (in_data.action == ACT_DATA && ph == PH_DATA) begin
      cur_nxt = cur_inc;
      cnt_nxt = cnt_inc;
      if (chunk_last) begin
        phase_nxt  = PH_POLL;
        len_nxt    = RUN_W'(3);
        run_nxt[0] = '{kind: K_RELEASE_AFTER, data: in_data.data_byte};
        run_nxt[1] = '{kind: K_KEEP, data: CMD_RDSR};
        run_nxt[2] = '{kind: K_POLL, data: 8'h00};
      end else begin
        run_nxt[0] = '{kind: K_KEEP, data: in_data.data_byte};
      end
    end else if (in_data.action == ACT_STATUS && ph == PH_POLL) begin
      if ((in_data.status_byte & SR_WIP) != 8'h00) begin
        run_nxt[0] = '{kind: K_POLL, data: 8'h00};
      end else if (cur_r < end_r) begin
        // flash ready and bytes remain: open the next chunk
        cnt_nxt    = '0;
        phase_nxt  = PH_DATA;
        len_nxt    = RUN_W'(6);
        run_nxt[0] = '{kind: K_RELEASE, data: 8'h00};
        run_nxt[1] = '{kind: K_RELEASE_AFTER, data: CMD_WREN};
        run_nxt[2] = '{kind: K_KEEP, data: CMD_PP};
        run_nxt[3] = '{kind: K_KEEP, data: open_addr[23:16]};
        run_nxt[4] = '{kind: K_KEEP, data: open_addr[15:8]};
        run_nxt[5] = '{kind: K_KEEP, data: open_addr[7:0]};
      end else begin
        phase_nxt  = PH_IDLE;
        len_nxt    = RUN_W'(2);
        run_nxt[0] = '{kind: K_RELEASE, data: 8'h00};
        run_nxt[1] = '{kind: K_DONE, data: 8'h00};
      end
    end
  end

  // state and run control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cur_r       <= '0;
      end_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      len_r       <= RUN_W'(1);
      wants_r     <= 1'b0;
    end else if (in_fire) begin
      phase_r     <= phase_nxt;
      cur_r       <= cur_nxt;
      end_r       <= end_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= 1'b1;
      idx_r       <= '0;
      len_r       <= len_nxt;
      wants_r     <= (phase_nxt == PH_DATA);
    end else if (out_fire) begin
      if (run_last) begin
        out_valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + RUN_W'(1);
      end
    end
  end

  // run entries are payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < RUN_MAX; i++) begin
        run_r[i] <= run_nxt[i];
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_data.result_kind = run_r[idx_r].kind;
  assign out_data.spi_byte    = run_r[idx_r].data;
  assign out_data.wants_data  = wants_r;
  assign out_data.last_of_run = run_last;

  // read pointer stays inside the run
  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (idx_r < len_r))
    else $error("run index beyond run length");

  // an accepted word always leaves a run to deliver
  a_fire_gives_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (out_valid_r && idx_r == '0 && len_r != '0))
    else $error("accepted word left no run");

  // wants_data follows the phase left by the word
  a_wants_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (wants_r == (phase_r == PH_DATA)))
    else $error("wants_data disagrees with phase");

  // chunk byte count stays below the page size while data is expected
  a_cnt_below_page: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (cnt_r < PAGE_LIM))
    else $error("chunk count reached page size in data phase");

endmodule
